/* hdl/dlts_pkg.sv */
// Delta list task scheduler: shared types and codes.
// No dependencies; imported by dlts_cell and delta_list_task_scheduler_top.
`timescale 1ns / 1ps
`default_nettype none

package dlts_pkg;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] delay;
    logic [7:0]  task_id;
    logic [31:0] period;
  } in_t;

  typedef struct packed {
    logic        dispatched_valid;
    logic [7:0]  dispatched_id;
    logic [31:0] dispatched_period;
    logic [31:0] head_delta;
    logic [5:0]  entry_count;
    logic [1:0]  status;
  } out_t;

  // One list entry: key is the absolute due time modulo 2^32 against a
  // running base; the wait from now is key - base.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [7:0]  task_id;
    logic [31:0] period;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] delay;  // wait of the inserted entry, relative to now
    logic [31:0] base;
    entry_t      ent;    // entry to insert
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/dlts_cell.sv */
// One cell of the scheduler list: holds one entry, compares and shifts.
// Depends on dlts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlts_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dlts_pkg::cell_ctrl_t ctrl_i,
  input  dlts_pkg::entry_t     prev_i,
  input  wire                  prev_after_i,
  input  dlts_pkg::entry_t     next_i,
  output dlts_pkg::entry_t     ent_o,
  output logic                 after_o
);
  import dlts_pkg::*;

  logic        vld_r;
  logic [31:0] key_r;
  logic [7:0]  id_r;
  logic [31:0] per_r;
  logic [31:0] cum;
  entry_t      ent_nxt;

  assign ent_o = '{valid: vld_r, key: key_r, task_id: id_r, period: per_r};

  // Total wait of this entry always fits 32 bits, so modular subtract is exact.
  always_comb begin
    cum     = key_r - ctrl_i.base;
    after_o = vld_r && (ctrl_i.delay >= cum);
  end

  always_comb begin
    ent_nxt = ent_o;
    unique case (ctrl_i.op)
      CELL_INS: begin
        if (!after_o) begin
          ent_nxt = prev_after_i ? ctrl_i.ent : prev_i;
        end
      end
      CELL_POP: begin
        ent_nxt = next_i;
      end
      default: begin
        ent_nxt = ent_o;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= ent_nxt.key;
    id_r  <= ent_nxt.task_id;
    per_r <= ent_nxt.period;
  end

endmodule

`default_nettype wire

/* hdl/delta_list_task_scheduler_top.sv */
// Add, or dispatch of a one-shot task, goes from S_IDLE to S_RESP at the input
// transfer; dispatch of a periodic task goes via S_REINS (re-insertion pass).
// Only S_IDLE takes a new item, so items do not overlap; each list update
// is one pass through the cell row. Reset (rst_n low, synchronous) empties the
// list and clears control state; entry payloads are left as they are.
// Top level: row of dlts_cell instances plus sequencer; depends on dlts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module delta_list_task_scheduler_top #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  dlts_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output dlts_pkg::out_t  out_data
);
  import dlts_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_REINS = 3'b010,
    S_RESP  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] base_r, base_nxt;

  // per-item result, captured at the input transfer
  logic        res_dv_r;
  logic [7:0]  res_id_r;
  logic [31:0] res_per_r;
  status_t     res_stat_r;

  logic        out_valid_r;
  out_t        out_r;

  cell_ctrl_t  ctrl;
  entry_t      cell_q [MAX_ENTRIES];
  logic        after  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld_vec;

  logic in_fire, full, empty, load_out;

  assign in_ready  = state_r == S_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign full      = count_r == CW'(MAX_ENTRIES);
  assign empty     = count_r == '0;
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // cell row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t pv, nx;
    logic   pa;
    if (i == 0) begin : g_first
      assign pv = '0;
      assign pa = 1'b1;
    end else begin : g_mid
      assign pv = cell_q[i-1];
      assign pa = after[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nx = '0;
    end else begin : g_nlast
      assign nx = cell_q[i+1];
    end
    dlts_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl),
      .prev_i       (pv),
      .prev_after_i (pa),
      .next_i       (nx),
      .ent_o        (cell_q[i]),
      .after_o      (after[i])
    );
    assign vld_vec[i] = cell_q[i].valid;
  end

  // list command and sequencing
  always_comb begin
    ctrl      = '0;
    ctrl.op   = CELL_HOLD;
    ctrl.base = base_r;
    state_nxt = state_r;
    count_nxt = count_r;
    base_nxt  = base_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_RESP;
          if (in_data.mode == MODE_ADD) begin
            if (!full) begin
              ctrl.op          = CELL_INS;
              ctrl.delay       = in_data.delay;
              ctrl.ent.valid   = 1'b1;
              ctrl.ent.key     = in_data.delay + base_r;
              ctrl.ent.task_id = in_data.task_id;
              ctrl.ent.period  = in_data.period;
              count_nxt        = count_r + 1'b1;
            end
          end else if (!empty) begin
            ctrl.op   = CELL_POP;
            base_nxt  = cell_q[0].key;
            count_nxt = count_r - 1'b1;
            if (cell_q[0].period != '0) begin
              state_nxt = S_REINS;
            end
          end
        end
      end
      S_REINS: begin
        ctrl.op          = CELL_INS;
        ctrl.delay       = res_per_r;
        ctrl.ent.valid   = 1'b1;
        ctrl.ent.key     = res_per_r + base_r;
        ctrl.ent.task_id = res_id_r;
        ctrl.ent.period  = res_per_r;
        count_nxt        = count_r + 1'b1;
        state_nxt        = S_RESP;
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      base_r  <= base_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_data.mode == MODE_ADD) begin
        res_dv_r   <= 1'b0;
        res_id_r   <= '0;
        res_per_r  <= '0;
        res_stat_r <= full ? STAT_FULL : STAT_OK;
      end else if (empty) begin
        res_dv_r   <= 1'b0;
        res_id_r   <= '0;
        res_per_r  <= '0;
        res_stat_r <= STAT_EMPTY;
      end else begin
        res_dv_r   <= 1'b1;
        res_id_r   <= cell_q[0].task_id;
        res_per_r  <= cell_q[0].period;
        res_stat_r <= STAT_OK;
      end
    end
    if (load_out) begin
      out_r.dispatched_valid  <= res_dv_r;
      out_r.dispatched_id     <= res_id_r;
      out_r.dispatched_period <= res_per_r;
      out_r.head_delta        <= cell_q[0].valid ? (cell_q[0].key - base_r) : '0;
      out_r.entry_count       <= 6'(count_r);
      out_r.status            <= res_stat_r;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("cell valid bits disagree with entry count");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec + 1'b1) & vld_vec) == '0)
    else $error("occupied cells are not a prefix of the row");

  a_reins_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REINS |-> !full && $past(state_r) == S_IDLE)
    else $error("re-insertion without a freed slot");
`endif

endmodule

`default_nettype wire

/* bench/dlts_sched_sb_pkg.sv */
// Scoreboard for the delta list task scheduler bench: list predictor and result checker.
// Depends on dlts_pkg for the transfer types, mode and status codes.
`timescale 1ns / 1ps

package dlts_sched_sb_pkg;
  import dlts_pkg::*;

  localparam int LIST_DEPTH = 32;

  class sched_scoreboard;
    bit [31:0] slot_ticks [LIST_DEPTH];
    bit [7:0]  slot_id    [LIST_DEPTH];
    bit [31:0] slot_period[LIST_DEPTH];
    int unsigned used;
    out_t due_results[$];
    int unsigned errors, checked, full_drops, empty_pops, repeats;

    // Insert after every entry whose total wait is <= ticks; the sum is kept 64 bits wide.
    function void place_task(bit [31:0] ticks, bit [7:0] id, bit [31:0] per);
      longint unsigned acc;
      int pos;
      acc = 0;
      pos = 0;
      while (pos < used && {32'b0, ticks} >= acc + slot_ticks[pos]) begin
        acc += slot_ticks[pos];
        pos++;
      end
      for (int i = used; i > pos; i--) begin
        slot_ticks[i]  = slot_ticks[i-1];
        slot_id[i]     = slot_id[i-1];
        slot_period[i] = slot_period[i-1];
      end
      slot_ticks[pos]  = ticks - acc[31:0];
      slot_id[pos]     = id;
      slot_period[pos] = per;
      if (pos + 1 <= used) slot_ticks[pos+1] -= slot_ticks[pos];
      used++;
    endfunction

    function void note_input(in_t it);
      out_t r;
      bit [7:0] hid;
      bit [31:0] hper;
      r = '0;
      if (it.mode == MODE_ADD) begin
        if (used >= LIST_DEPTH) begin
          r.status = STAT_FULL;
          full_drops++;
        end else begin
          place_task(it.delay, it.task_id, it.period);
        end
      end else if (used == 0) begin
        r.status = STAT_EMPTY;
        empty_pops++;
      end else begin
        hid  = slot_id[0];
        hper = slot_period[0];
        for (int i = 0; i + 1 < used; i++) begin
          slot_ticks[i]  = slot_ticks[i+1];
          slot_id[i]     = slot_id[i+1];
          slot_period[i] = slot_period[i+1];
        end
        used--;
        if (hper != 0) begin
          place_task(hper, hid, hper);
          repeats++;
        end
        r.dispatched_valid  = 1'b1;
        r.dispatched_id     = hid;
        r.dispatched_period = hper;
      end
      r.head_delta  = (used > 0) ? slot_ticks[0] : 32'd0;
      r.entry_count = used[5:0];
      due_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH %s", what);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
    endtask

    task check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: id %0h count %0d",
                                  got.dispatched_id, got.entry_count));
        return;
      end
      want = due_results.pop_front();
      checked++;
      check_field("dispatched_valid", got.dispatched_valid, want.dispatched_valid);
      check_field("dispatched_id", got.dispatched_id, want.dispatched_id);
      check_field("dispatched_period", got.dispatched_period, want.dispatched_period);
      check_field("head_delta", got.head_delta, want.head_delta);
      check_field("entry_count", got.entry_count, want.entry_count);
      check_field("status", got.status, want.status);
    endtask

    function int pending();
      return due_results.size();
    endfunction

    function int unsigned periodic_held();
      int unsigned n;
      n = 0;
      for (int i = 0; i < used; i++)
        if (slot_period[i] != 0) n++;
      return n;
    endfunction
  endclass

endpackage

/* bench/tb_delta_list_task_scheduler_top.sv */
// Bench top for delta_list_task_scheduler_top: directed and random add/dispatch traffic
// with random stalls on both channels. Depends on dlts_pkg and dlts_sched_sb_pkg.
`timescale 1ns / 1ps

module tb_delta_list_task_scheduler_top;
  import dlts_pkg::*;
  import dlts_sched_sb_pkg::*;

  localparam int RANDOM_ITEMS = 1080;
  localparam int QUIET_TAIL   = 150;
  localparam int HANG_LIMIT   = 1000;
  localparam int MAX_PERIODIC = 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  sched_scoreboard sb = new();
  bit quiet = 1'b0;
  bit calm = 1'b0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  delta_list_task_scheduler_top #(.MAX_ENTRIES(LIST_DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  function automatic in_t item_of(logic m, logic [31:0] d, logic [7:0] id, logic [31:0] p);
    in_t it;
    it.mode    = m;
    it.delay   = d;
    it.task_id = id;
    it.period  = p;
    return it;
  endfunction

  // Small waits give plenty of equal due times; large ones push the running sum past 32 bits.
  function automatic logic [31:0] pick_ticks();
    logic [31:0] t;
    case ($urandom_range(0, 3))
      0: t = $urandom_range(0, 7);
      1: t = $urandom_range(0, 1000);
      2: t = $urandom;
      default: t = 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
    return t;
  endfunction

  // Periodic tasks never leave the list, so only a few are let in.
  function automatic in_t make_item(int add_pct);
    in_t it;
    it.mode    = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_DISPATCH;
    it.delay   = pick_ticks();
    it.task_id = 8'($urandom_range(0, 255));
    it.period  = 32'd0;
    if (it.mode == MODE_DISPATCH || sb.used >= LIST_DEPTH)
      it.period = $urandom;
    else if (sb.periodic_held() < MAX_PERIODIC && $urandom_range(0, 99) < 10)
      it.period = pick_ticks();
    return it;
  endfunction

  task automatic put_item(input in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent++;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    @(negedge rst_n or posedge rst_n);
    wait (rst_n);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat (60) @(posedge clk);
      else repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Hang detection: no transfer on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HANG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned seg_len;
    int add_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dispatch, extremes, equal due times, periodic re-insertion
    put_item(item_of(MODE_DISPATCH, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    put_item(item_of(MODE_ADD, 32'd0, 8'h00, 32'd0));
    put_item(item_of(MODE_ADD, 32'hFFFF_FFFF, 8'hFF, 32'd0));
    put_item(item_of(MODE_ADD, 32'd5, 8'h01, 32'd0));
    put_item(item_of(MODE_ADD, 32'd5, 8'h02, 32'd0));
    put_item(item_of(MODE_ADD, 32'd5, 8'h03, 32'd0));
    put_item(item_of(MODE_ADD, 32'd0, 8'h04, 32'd0));
    put_item(item_of(MODE_ADD, 32'hFFFF_FFFF, 8'h05, 32'd0));
    put_item(item_of(MODE_ADD, 32'd3, 8'h06, 32'hFFFF_FFFF));
    put_item(item_of(MODE_ADD, 32'd2, 8'h07, 32'd7));
    repeat (10) put_item(item_of(MODE_DISPATCH, 32'd0, 8'h00, 32'd0));

    // random: segments lean toward filling, draining or neither
    while (sent < RANDOM_ITEMS + 20) begin
      seg_len = $urandom_range(20, 90);
      case ($urandom_range(0, 2))
        0: add_pct = 85;
        1: add_pct = 20;
        default: add_pct = 55;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        if (sent + QUIET_TAIL >= RANDOM_ITEMS + 20) quiet = 1'b1;
        if (sent < RANDOM_ITEMS + 20) put_item(make_item(add_pct));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Summary: %0d items, %0d results checked, %0d full-list drops, %0d empty dispatches",
             sent, sb.checked, sb.full_drops, sb.empty_pops);
    $display("Summary: %0d periodic re-insertions, %0d mismatches", sb.repeats, sb.errors);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* delta_list_task_scheduler_top.f */
hdl/dlts_pkg.sv
hdl/dlts_cell.sv
hdl/delta_list_task_scheduler_top.sv
bench/dlts_sched_sb_pkg.sv
bench/tb_delta_list_task_scheduler_top.sv
